@@ rtl/spq_pkg.sv @@
// shared types, constants and codes for the sorted priority queue
package spq_pkg;

    localparam int URG_W        = 16;
    localparam int PAY_W        = 32;
    localparam int CNT_OUT_W    = 5;
    localparam int DEF_CAPACITY = 16;

    // request command codes
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } command_t;

    // status codes reported with every result
    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2
    } status_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } cell_ctrl_t;

    // one result as it travels through the output buffer
    typedef struct packed {
        logic signed [PAY_W-1:0]     head_payload;
        logic signed [URG_W-1:0]     head_urgency;
        logic                        queue_empty;
        logic                        queue_full;
        logic        [CNT_OUT_W-1:0] entry_count;
        status_t                     status;
    } result_t;

endpackage

@@ rtl/sorted_priority_queue.sv @@
// top level of the sorted priority queue: cell chain, entry count and result buffer
//
// Bounded priority queue of CAPACITY entries kept sorted largest urgency first, as a
// row of cells that each hold one entry. An insert is broadcast to all cells: each
// cell compares its urgency with the new one and either keeps its entry, takes the
// new entry, or takes its left neighbor's; equal urgencies leave in arrival order.
// A remove shifts every cell from its right neighbor. One request (insert or
// remove) is accepted per clock at any CAPACITY while in_stall is low, a rate set
// by the single compare-and-shift step in each cell. Each request gives one
// result through an output register with a skid stage: the result is registered
// in the output register, or in the skid stage while a stalled result waits there,
// so one more request is taken while it waits. Insert into a full queue is dropped
// with status 1, remove on an empty queue changes nothing with status 2; head
// fields read zero when empty. entry_count is the count wrapped to 5 bits.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    command,
    input  logic signed [spq_pkg::URG_W-1:0]        urgency,
    input  logic signed [spq_pkg::PAY_W-1:0]        payload,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [spq_pkg::PAY_W-1:0]        head_payload,
    output logic signed [spq_pkg::URG_W-1:0]        head_urgency,
    output logic                                    queue_empty,
    output logic                                    queue_full,
    output logic        [spq_pkg::CNT_OUT_W-1:0]    entry_count,
    output logic        [1:0]                       status
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                accept;
    logic                is_empty;
    logic                is_full;
    spq_pkg::cell_ctrl_t ctrl;
    spq_pkg::status_t    step_status;
    spq_pkg::result_t    result;
    spq_pkg::result_t    out_data;

    logic [CAPACITY-1:0]                    occ;
    logic [CAPACITY-1:0]                    ahead;
    logic signed [spq_pkg::URG_W-1:0]       cell_urg      [CAPACITY];
    logic signed [spq_pkg::PAY_W-1:0]       cell_pay      [CAPACITY];
    logic signed [spq_pkg::URG_W-1:0]       cell_urg_next [CAPACITY];
    logic signed [spq_pkg::PAY_W-1:0]       cell_pay_next [CAPACITY];

    assign accept   = in_valid && !in_stall;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(CAPACITY));

    // decode the request into cell control and status
    always_comb
    begin
        ctrl.do_insert = 1'b0;
        ctrl.do_remove = 1'b0;
        step_status    = spq_pkg::ST_DONE;
        count_next     = count_reg;
        unique case (spq_pkg::command_t'(command))
            spq_pkg::CMD_INSERT:
            begin
                if (is_full)
                begin
                    step_status = spq_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.do_insert = accept;
                    count_next     = count_reg + 1'b1;
                end
            end
            spq_pkg::CMD_REMOVE:
            begin
                if (is_empty)
                begin
                    step_status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.do_remove = accept;
                    count_next     = count_reg - 1'b1;
                end
            end
            default:
            begin
                step_status = spq_pkg::ST_DONE;
            end
        endcase
    end

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // chain of cells
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                               l_ahead;
            logic signed [spq_pkg::URG_W-1:0]   l_urg;
            logic signed [spq_pkg::PAY_W-1:0]   l_pay;
            logic signed [spq_pkg::URG_W-1:0]   r_urg;
            logic signed [spq_pkg::PAY_W-1:0]   r_pay;

            assign occ[i] = (count_reg > CW'(i));

            if (i == 0)
            begin : g_first
                assign l_ahead = 1'b1;
                assign l_urg   = urgency;
                assign l_pay   = payload;
            end
            else
            begin : g_mid
                assign l_ahead = ahead[i-1];
                assign l_urg   = cell_urg[i-1];
                assign l_pay   = cell_pay[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign r_urg = cell_urg[i];
                assign r_pay = cell_pay[i];
            end
            else
            begin : g_inner
                assign r_urg = cell_urg[i+1];
                assign r_pay = cell_pay[i+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occ        (occ[i]),
                .new_urg    (urgency),
                .new_pay    (payload),
                .left_ahead (l_ahead),
                .left_urg   (l_urg),
                .left_pay   (l_pay),
                .right_urg  (r_urg),
                .right_pay  (r_pay),
                .ahead      (ahead[i]),
                .urg        (cell_urg[i]),
                .pay        (cell_pay[i]),
                .urg_next   (cell_urg_next[i]),
                .pay_next   (cell_pay_next[i])
            );
        end
    endgenerate

    // result after this request
    always_comb
    begin
        result.queue_empty = (count_next == '0);
        result.queue_full  = (count_next == CW'(CAPACITY));
        result.entry_count = spq_pkg::CNT_OUT_W'(count_next);
        result.status      = step_status;
        if (count_next == '0)
        begin
            result.head_payload = '0;
            result.head_urgency = '0;
        end
        else
        begin
            result.head_payload = cell_pay_next[0];
            result.head_urgency = cell_urg_next[0];
        end
    end

    spq_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (result),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );

    assign head_payload = out_data.head_payload;
    assign head_urgency = out_data.head_urgency;
    assign queue_empty  = out_data.queue_empty;
    assign queue_full   = out_data.queue_full;
    assign entry_count  = out_data.entry_count;
    assign status       = out_data.status;

endmodule

@@ rtl/spq_cell.sv @@
// one slot of the sorted chain: holds an entry, compares, shifts with its neighbors
module spq_cell (
    input  logic                                clk,
    input  spq_pkg::cell_ctrl_t                 ctrl,
    input  logic                                occ,
    input  logic signed [spq_pkg::URG_W-1:0]    new_urg,
    input  logic signed [spq_pkg::PAY_W-1:0]    new_pay,
    input  logic                                left_ahead,
    input  logic signed [spq_pkg::URG_W-1:0]    left_urg,
    input  logic signed [spq_pkg::PAY_W-1:0]    left_pay,
    input  logic signed [spq_pkg::URG_W-1:0]    right_urg,
    input  logic signed [spq_pkg::PAY_W-1:0]    right_pay,
    output logic                                ahead,
    output logic signed [spq_pkg::URG_W-1:0]    urg,
    output logic signed [spq_pkg::PAY_W-1:0]    pay,
    output logic signed [spq_pkg::URG_W-1:0]    urg_next,
    output logic signed [spq_pkg::PAY_W-1:0]    pay_next
);

    logic signed [spq_pkg::URG_W-1:0] urg_reg;
    logic signed [spq_pkg::PAY_W-1:0] pay_reg;

    // stored entry stays ahead of the new one when its urgency is equal or greater
    assign ahead = occ && (urg_reg >= new_urg);

    // next entry: keep, take the new one, shift from the left or shift from the right
    always_comb
    begin
        urg_next = urg_reg;
        pay_next = pay_reg;
        if (ctrl.do_insert && !ahead)
        begin
            if (left_ahead)
            begin
                urg_next = new_urg;
                pay_next = new_pay;
            end
            else
            begin
                urg_next = left_urg;
                pay_next = left_pay;
            end
        end
        else if (ctrl.do_remove)
        begin
            urg_next = right_urg;
            pay_next = right_pay;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        urg_reg <= urg_next;
        pay_reg <= pay_next;
    end

    assign urg = urg_reg;
    assign pay = pay_reg;

endmodule

@@ rtl/spq_out_buf.sv @@
// output register with a skid stage so a request can be taken while a result waits
module spq_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  spq_pkg::result_t in_data,
    output logic             in_stall,
    output logic             out_valid,
    output spq_pkg::result_t out_data,
    input  logic             out_stall
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    spq_pkg::result_t out_data_reg;
    spq_pkg::result_t out_data_next;
    spq_pkg::result_t skid_data_reg;
    spq_pkg::result_t skid_data_next;
    logic             take;
    logic             drain;

    assign in_stall = skid_valid_reg;
    assign take     = in_valid && !skid_valid_reg;
    assign drain    = !out_valid_reg || !out_stall;

    // steer a new result into the output register or the skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (drain)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = take;
                out_data_next  = in_data;
            end
        end
        else if (take)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result data
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ tb/queue_checker.sv @@
// checker for the sorted priority queue: tracks the entry store and compares every result
`timescale 1ns / 100ps
module queue_checker #(
    parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic                                    command,
    input  logic signed [spq_pkg::URG_W-1:0]        urgency,
    input  logic signed [spq_pkg::PAY_W-1:0]        payload,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic signed [spq_pkg::PAY_W-1:0]        head_payload,
    input  logic signed [spq_pkg::URG_W-1:0]        head_urgency,
    input  logic                                    queue_empty,
    input  logic                                    queue_full,
    input  logic        [spq_pkg::CNT_OUT_W-1:0]    entry_count,
    input  logic        [1:0]                       status,
    output int                                      mismatches,
    output int                                      awaiting
);

    // shadow copy of the sorted store, slot 0 is the head
    logic signed [spq_pkg::URG_W-1:0] slot_urg [CAPACITY];
    logic signed [spq_pkg::PAY_W-1:0] slot_pay [CAPACITY];
    int unsigned                      held = 0;

    // results owed by the block, oldest first
    spq_pkg::result_t                 due_results [$];
    int                               errs = 0;

    assign mismatches = errs;

    // apply one request to the shadow store and return the result it owes
    function automatic spq_pkg::result_t apply_request(
        spq_pkg::command_t                cmd,
        logic signed [spq_pkg::URG_W-1:0] urg,
        logic signed [spq_pkg::PAY_W-1:0] pay);
        spq_pkg::result_t r;
        int unsigned      pos;
        int unsigned      k;
        r.status = spq_pkg::ST_DONE;
        if (cmd == spq_pkg::CMD_INSERT) begin
            if (held >= CAPACITY) begin
                r.status = spq_pkg::ST_FULL;
            end
            else begin
                // new entry goes behind every entry of equal or higher urgency
                pos = 0;
                while (pos < held && slot_urg[pos] >= urg)
                    pos++;
                for (k = held; k > pos; k--) begin
                    slot_urg[k] = slot_urg[k-1];
                    slot_pay[k] = slot_pay[k-1];
                end
                slot_urg[pos] = urg;
                slot_pay[pos] = pay;
                held++;
            end
        end
        else begin
            if (held == 0) begin
                r.status = spq_pkg::ST_EMPTY;
            end
            else begin
                for (k = 1; k < held; k++) begin
                    slot_urg[k-1] = slot_urg[k];
                    slot_pay[k-1] = slot_pay[k];
                end
                held--;
            end
        end
        // head fields read zero on an empty queue
        r.head_payload = (held != 0) ? slot_pay[0] : '0;
        r.head_urgency = (held != 0) ? slot_urg[0] : '0;
        r.queue_empty  = (held == 0);
        r.queue_full   = (held >= CAPACITY);
        r.entry_count  = spq_pkg::CNT_OUT_W'(held);
        return r;
    endfunction

    // watch both channels, predict on request, compare on result
    always @(posedge clk or negedge rst_n) begin : track
        spq_pkg::result_t want;
        if (!rst_n) begin
            held = 0;
            due_results.delete();
            awaiting <= 0;
        end
        else begin
            if (in_valid && !in_stall)
                due_results.push_back(
                    apply_request(spq_pkg::command_t'(command), urgency, payload));
            if (out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    errs++;
                    $error("result with no request pending");
                end
                else begin
                    want = due_results.pop_front();
                    if (head_payload !== want.head_payload) begin
                        errs++;
                        $error("head_payload: expected %0d, got %0d",
                               want.head_payload, head_payload);
                    end
                    if (head_urgency !== want.head_urgency) begin
                        errs++;
                        $error("head_urgency: expected %0d, got %0d",
                               want.head_urgency, head_urgency);
                    end
                    if (queue_empty !== want.queue_empty) begin
                        errs++;
                        $error("queue_empty: expected %0d, got %0d",
                               want.queue_empty, queue_empty);
                    end
                    if (queue_full !== want.queue_full) begin
                        errs++;
                        $error("queue_full: expected %0d, got %0d",
                               want.queue_full, queue_full);
                    end
                    if (entry_count !== want.entry_count) begin
                        errs++;
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, entry_count);
                    end
                    if (status !== want.status) begin
                        errs++;
                        $error("status: expected %0d, got %0d", want.status, status);
                    end
                end
            end
            awaiting <= due_results.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// top of the sorted priority queue testbench: clock, reset, request traffic and verdict
`timescale 1ns / 100ps
module testbench;

    localparam int CAPACITY    = spq_pkg::DEF_CAPACITY;
    localparam int STUCK_LIMIT = 2000;

    logic                                 clk          = 1'b0;
    logic                                 rst_n        = 1'b0;
    logic                                 in_valid     = 1'b0;
    logic                                 in_stall;
    logic                                 command      = spq_pkg::CMD_INSERT;
    logic signed [spq_pkg::URG_W-1:0]     urgency      = '0;
    logic signed [spq_pkg::PAY_W-1:0]     payload      = '0;
    logic                                 out_valid;
    logic                                 out_stall    = 1'b0;
    logic signed [spq_pkg::PAY_W-1:0]     head_payload;
    logic signed [spq_pkg::URG_W-1:0]     head_urgency;
    logic                                 queue_empty;
    logic                                 queue_full;
    logic        [spq_pkg::CNT_OUT_W-1:0] entry_count;
    logic        [1:0]                    status;

    int                                   mismatches;
    int                                   awaiting;
    int unsigned                          gap_pct      = 0;
    int unsigned                          stall_pct    = 0;
    int unsigned                          calm_in      = 0;
    int unsigned                          calm_out     = 0;
    int                                   stuck        = 0;

    always #5 clk = ~clk;

    sorted_priority_queue #(.CAPACITY(CAPACITY)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .urgency      (urgency),
        .payload      (payload),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .head_payload (head_payload),
        .head_urgency (head_urgency),
        .queue_empty  (queue_empty),
        .queue_full   (queue_full),
        .entry_count  (entry_count),
        .status       (status)
    );

    queue_checker #(.CAPACITY(CAPACITY)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .urgency      (urgency),
        .payload      (payload),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .head_payload (head_payload),
        .head_urgency (head_urgency),
        .queue_empty  (queue_empty),
        .queue_full   (queue_full),
        .entry_count  (entry_count),
        .status       (status),
        .mismatches   (mismatches),
        .awaiting     (awaiting)
    );

    // receiver stall, with occasional stretches of no stall
    always @(posedge clk) begin
        if (calm_out > 0) begin
            calm_out--;
            out_stall <= 1'b0;
        end
        else begin
            if ($urandom_range(99) < 3)
                calm_out = $urandom_range(40, 10);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= STUCK_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // present one request, idling first at random, and hold it until accepted
    task automatic send_request(spq_pkg::command_t cmd,
                                logic signed [spq_pkg::URG_W-1:0] urg,
                                logic signed [spq_pkg::PAY_W-1:0] pay);
        if (calm_in > 0)
            calm_in--;
        else if ($urandom_range(99) < 4)
            calm_in = $urandom_range(40, 10);
        while (calm_in == 0 && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        urgency  <= urg;
        payload  <= pay;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // random traffic in stretches that lean toward filling, draining or neither
    task automatic random_requests(int unsigned count);
        int unsigned                      i;
        int unsigned                      insert_pct;
        spq_pkg::command_t                cmd;
        logic signed [spq_pkg::URG_W-1:0] urg;
        insert_pct = 50;
        for (i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            cmd = ($urandom_range(99) < insert_pct) ? spq_pkg::CMD_INSERT
                                                    : spq_pkg::CMD_REMOVE;
            case ($urandom_range(3))
                // narrow range for plenty of equal urgencies
                0: urg = spq_pkg::URG_W'($urandom_range(3));
                1: begin
                    case ($urandom_range(3))
                        0:       urg = 16'sh7fff;
                        1:       urg = 16'sh8000;
                        2:       urg = '1;
                        default: urg = '0;
                    endcase
                end
                default: urg = spq_pkg::URG_W'($urandom);
            endcase
            send_request(cmd, urg, spq_pkg::PAY_W'($urandom));
        end
    endtask

    task automatic run_phase(int unsigned gap, int unsigned stall, int unsigned count);
        gap_pct   = gap;
        stall_pct = stall;
        random_requests(count);
    endtask

    // stimulus and verdict
    initial begin
        int k;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // remove on empty, extremes, equal urgencies, fill up, insert on full, drain a bit
        send_request(spq_pkg::CMD_REMOVE, '0, '0);
        send_request(spq_pkg::CMD_INSERT, 16'sh7fff, 32'sh7fffffff);
        send_request(spq_pkg::CMD_INSERT, 16'sh8000, 32'sh80000000);
        send_request(spq_pkg::CMD_INSERT, '0, '0);
        for (k = 1; k <= 3; k++)
            send_request(spq_pkg::CMD_INSERT, 16'sd5, spq_pkg::PAY_W'(k));
        send_request(spq_pkg::CMD_INSERT, '1, '1);
        // ties at both extremes must keep arrival order
        for (k = 0; k < 9; k++)
            send_request(spq_pkg::CMD_INSERT, (k % 2) ? 16'sh7fff : 16'sh8000,
                         spq_pkg::PAY_W'(100 + k));
        send_request(spq_pkg::CMD_INSERT, 16'sd5, 32'sh5a5a5a5a);
        repeat (4) send_request(spq_pkg::CMD_REMOVE, 16'sh1234, 32'sh00001234);

        run_phase(0, 0, 175);
        run_phase(61, 0, 175);
        run_phase(0, 61, 175);
        run_phase(21, 21, 175);

        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
